// ===== rtl/mqlf_pkg.sv =====
// Shared constants and types for the linked multi-queue FIFO manager.
`timescale 1ns / 1ps
package mqlf_pkg;
  localparam int NUM_QUEUES   = 16;
  localparam int POOL_ENTRIES = 64;
  localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW     = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int LEN_W  = $clog2(POOL_ENTRIES + 1);
  localparam int TOT_W  = $clog2(NUM_QUEUES + 1);
  localparam int ID_W   = 8;
  localparam int TAG_W  = 64;
  localparam int CNT_W  = 7;

  typedef enum logic [1:0] {
    FN_CREATE = 2'd0,
    FN_ENQ    = 2'd1,
    FN_DEQ    = 2'd2,
    FN_LIST   = 2'd3
  } func_t;

  typedef enum logic [5:0] {
    ST_INIT  = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_EXEC  = 6'b000100,
    ST_WALK  = 6'b001000,
    ST_POP   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  typedef struct packed {
    logic             wr_en;
    logic [PW-1:0]    wr_addr;
    logic [TAG_W-1:0] wr_data;
    logic [PW-1:0]    rd_addr;
  } stack_ctl_t;
endpackage

// ===== rtl/multi_queue_linked_fifo.sv =====
// Linked multi-queue FIFO manager: shared entry pool, per-queue head, tail and length.
// Create, enqueue and dequeue pass one link/tag memory read, then the output register, from input beat to result.
// A list of n entries walks the chain into the tag stack, then emits each result beat through the POP and EMIT states.
// One item is worked on at a time; the output register lets the next beat enter meanwhile.
// After reset an init pass chains every link memory entry into the free list; no beat enters then.
`timescale 1ns / 1ps
module multi_queue_linked_fifo (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_func,
  input  logic [mqlf_pkg::ID_W-1:0]        in_queue_id,
  input  logic [mqlf_pkg::TAG_W-1:0]       in_tag,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_status,
  output logic [mqlf_pkg::CNT_W-1:0]       out_count,
  output logic [mqlf_pkg::TAG_W-1:0]       out_tag,
  output logic                             out_last
);
  localparam int PW    = mqlf_pkg::PW;
  localparam int QW    = mqlf_pkg::QW;
  localparam int LEN_W = mqlf_pkg::LEN_W;
  localparam int TOT_W = mqlf_pkg::TOT_W;
  localparam int TAG_W = mqlf_pkg::TAG_W;
  localparam int CNT_W = mqlf_pkg::CNT_W;
  localparam int NQ    = mqlf_pkg::NUM_QUEUES;
  localparam int NP    = mqlf_pkg::POOL_ENTRIES;

  mqlf_pkg::state_t state_r, state_nxt;

  logic [PW-1:0]    link_mem [NP];
  logic [TAG_W-1:0] tag_mem  [NP];
  logic [PW-1:0]    link_rd_r;
  logic [TAG_W-1:0] tag_rd_r;
  logic [PW-1:0]    rd_addr;
  logic             rd_en;

  logic             link_we;
  logic [PW-1:0]    link_wa, link_wd;
  logic             tag_we;

  logic [NQ-1:0]    qvalid_r, qvalid_nxt;
  logic [LEN_W-1:0] qlen_r [NQ];
  logic [LEN_W-1:0] qlen_nxt [NQ];
  logic [PW-1:0]    head_r [NQ];
  logic [PW-1:0]    head_nxt [NQ];
  logic [PW-1:0]    tail_r [NQ];
  logic [PW-1:0]    tail_nxt [NQ];

  logic [PW-1:0]    free_head_r, free_head_nxt;
  logic [LEN_W-1:0] free_count_r, free_count_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;

  mqlf_pkg::func_t  func_r;
  logic [QW-1:0]    qidx_r;
  logic             id_ok_r;
  logic [TAG_W-1:0] tag_r;

  logic [PW-1:0]    init_cnt_r, init_cnt_nxt;
  logic [PW-1:0]    cnt_r, cnt_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_status_r, out_status_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;
  logic [TAG_W-1:0] out_tag_r, out_tag_nxt;
  logic             out_last_r, out_last_nxt;

  mqlf_pkg::stack_ctl_t stk;
  logic [TAG_W-1:0] stk_rd;

  logic             accept, out_free;
  logic [QW-1:0]    in_qidx;
  logic             in_id_ok;
  logic [LEN_W-1:0] cur_len;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != mqlf_pkg::ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign in_id_ok = (in_queue_id != '0) && ({24'd0, in_queue_id} <= 32'(NQ));
  assign in_qidx  = QW'(in_queue_id - 8'd1);
  assign cur_len  = qlen_r[qidx_r];
  assign rd_en    = (state_r != mqlf_pkg::ST_EXEC) || out_free;

  always_comb begin
    if (state_r == mqlf_pkg::ST_IDLE) begin
      if (in_func == mqlf_pkg::FN_DEQ || in_func == mqlf_pkg::FN_LIST) begin
        rd_addr = head_r[in_qidx];
      end else begin
        rd_addr = free_head_r;
      end
    end else begin
      rd_addr = link_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (tag_we) begin
      tag_mem[free_head_r] <= tag_r;
    end
    if (rd_en) begin
      link_rd_r <= link_mem[rd_addr];
      tag_rd_r  <= tag_mem[rd_addr];
    end
  end

  mqlf_stack u_stack (
    .clk     (clk),
    .ctl     (stk),
    .rd_data (stk_rd)
  );

  always_comb begin
    state_nxt      = state_r;
    qvalid_nxt     = qvalid_r;
    qlen_nxt       = qlen_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    free_head_nxt  = free_head_r;
    free_count_nxt = free_count_r;
    total_nxt      = total_r;
    init_cnt_nxt   = init_cnt_r;
    cnt_nxt        = cnt_r;
    link_we        = 1'b0;
    link_wa        = init_cnt_r;
    link_wd        = (init_cnt_r == PW'(NP - 1)) ? '0 : init_cnt_r + PW'(1);
    tag_we         = 1'b0;
    stk.wr_en      = 1'b0;
    stk.wr_addr    = cnt_r;
    stk.wr_data    = tag_rd_r;
    stk.rd_addr    = cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_tag_nxt    = out_tag_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      mqlf_pkg::ST_INIT: begin
        link_we      = 1'b1;
        init_cnt_nxt = init_cnt_r + PW'(1);
        if (init_cnt_r == PW'(NP - 1)) begin
          state_nxt = mqlf_pkg::ST_IDLE;
        end
      end
      mqlf_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = mqlf_pkg::ST_EXEC;
        end
      end
      mqlf_pkg::ST_EXEC: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = 1'b1;
          out_count_nxt  = '0;
          out_tag_nxt    = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = mqlf_pkg::ST_IDLE;
          if (id_ok_r) begin
            case (func_r)
              mqlf_pkg::FN_CREATE: begin
                if (!qvalid_r[qidx_r]) begin
                  qvalid_nxt[qidx_r] = 1'b1;
                  qlen_nxt[qidx_r]   = '0;
                  total_nxt          = total_r + TOT_W'(1);
                  out_status_nxt     = 1'b0;
                  out_count_nxt      = CNT_W'(total_r + TOT_W'(1));
                end
              end
              mqlf_pkg::FN_ENQ: begin
                if (qvalid_r[qidx_r] && free_count_r != '0) begin
                  free_head_nxt  = link_rd_r;
                  free_count_nxt = free_count_r - LEN_W'(1);
                  tag_we         = 1'b1;
                  if (cur_len == '0) begin
                    head_nxt[qidx_r] = free_head_r;
                  end else begin
                    link_we = 1'b1;
                    link_wa = tail_r[qidx_r];
                    link_wd = free_head_r;
                  end
                  tail_nxt[qidx_r] = free_head_r;
                  qlen_nxt[qidx_r] = cur_len + LEN_W'(1);
                  out_status_nxt   = 1'b0;
                  out_count_nxt    = CNT_W'(cur_len + LEN_W'(1));
                end
              end
              mqlf_pkg::FN_DEQ: begin
                if (qvalid_r[qidx_r] && cur_len != '0) begin
                  out_status_nxt   = 1'b0;
                  out_tag_nxt      = tag_rd_r;
                  head_nxt[qidx_r] = link_rd_r;
                  qlen_nxt[qidx_r] = cur_len - LEN_W'(1);
                  link_we          = 1'b1;
                  link_wa          = head_r[qidx_r];
                  link_wd          = free_head_r;
                  free_head_nxt    = head_r[qidx_r];
                  free_count_nxt   = free_count_r + LEN_W'(1);
                end
              end
              default: begin
                if (qvalid_r[qidx_r] && cur_len != '0) begin
                  out_valid_nxt = out_valid_r && out_stall;
                  stk.wr_en     = 1'b1;
                  stk.wr_addr   = '0;
                  if (cur_len == LEN_W'(1)) begin
                    cnt_nxt   = '0;
                    state_nxt = mqlf_pkg::ST_POP;
                  end else begin
                    cnt_nxt   = PW'(1);
                    state_nxt = mqlf_pkg::ST_WALK;
                  end
                end
              end
            endcase
          end
        end
      end
      mqlf_pkg::ST_WALK: begin
        stk.wr_en = 1'b1;
        if ({1'b0, cnt_r} == LEN_W'(cur_len - LEN_W'(1))) begin
          state_nxt = mqlf_pkg::ST_POP;
        end else begin
          cnt_nxt = cnt_r + PW'(1);
        end
      end
      mqlf_pkg::ST_POP: begin
        state_nxt = mqlf_pkg::ST_EMIT;
      end
      mqlf_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = 1'b0;
          out_count_nxt  = '0;
          out_tag_nxt    = stk_rd;
          out_last_nxt   = (cnt_r == '0);
          if (cnt_r == '0) begin
            state_nxt = mqlf_pkg::ST_IDLE;
          end else begin
            cnt_nxt   = cnt_r - PW'(1);
            state_nxt = mqlf_pkg::ST_POP;
          end
        end
      end
      default: begin
        state_nxt = mqlf_pkg::ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mqlf_pkg::ST_INIT;
      init_cnt_r   <= '0;
      qvalid_r     <= '0;
      free_head_r  <= '0;
      free_count_r <= LEN_W'(NP);
      total_r      <= '0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
      for (int i = 0; i < NQ; i++) begin
        qlen_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      init_cnt_r   <= init_cnt_nxt;
      qvalid_r     <= qvalid_nxt;
      free_head_r  <= free_head_nxt;
      free_count_r <= free_count_nxt;
      total_r      <= total_nxt;
      out_valid_r  <= out_valid_nxt;
      cnt_r        <= cnt_nxt;
      qlen_r       <= qlen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r       <= head_nxt;
    tail_r       <= tail_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_tag_r    <= out_tag_nxt;
    out_last_r   <= out_last_nxt;
    if (accept) begin
      func_r  <= mqlf_pkg::func_t'(in_func);
      qidx_r  <= in_qidx;
      id_ok_r <= in_id_ok;
      tag_r   <= in_tag;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;
  assign out_tag    = out_tag_r;
  assign out_last   = out_last_r;

`ifndef NO_ASSERTIONS
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == mqlf_pkg::ST_EXEC)
    else $error("accepted beat did not enter execution");
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r <= LEN_W'(NP))
    else $error("free entry count above pool size");
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TOT_W'(NQ))
    else $error("queue total above queue count");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(out_tag_r))
    else $error("stalled result beat changed");
`endif
endmodule

// ===== rtl/mqlf_stack.sv =====
// Tag stack that reverses a walked queue chain for newest-first listing.
`timescale 1ns / 1ps
module mqlf_stack (
  input  logic                           clk,
  input  mqlf_pkg::stack_ctl_t           ctl,
  output logic [mqlf_pkg::TAG_W-1:0]     rd_data
);
  logic [mqlf_pkg::TAG_W-1:0] mem [mqlf_pkg::POOL_ENTRIES];
  logic [mqlf_pkg::TAG_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    rd_data_r <= mem[ctl.rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule
